FILE: hdl/wes_pkg.sv
// wes_pkg: shared widths, register indexes, cell gain codes and reset values
// for the wave equation stencil step block
// no dependencies
package wes_pkg;

  localparam int VAL_W   = 32;  // signed Q16.16 sample
  localparam int LAP_W   = 36;  // exact five-point laplacian
  localparam int COEF_W  = 16;  // unsigned Q0.16 gain
  localparam int COORD_W = 10;  // row / col on the result
  localparam int GRID_W  = 11;  // grid_size register
  localparam int CFG_W   = 16;  // widest register
  localparam int IDX_W   = 2;   // register index
  localparam int IN_W    = 64;  // input tdata
  localparam int OUT_W   = 56;  // output tdata, padded to bytes

  localparam logic [IDX_W-1:0] REG_GRID_SIZE  = 2'd0;
  localparam logic [IDX_W-1:0] REG_COEF       = 2'd1;
  localparam logic [IDX_W-1:0] REG_COEF_FIRST = 2'd2;
  localparam logic [IDX_W-1:0] REG_FIRST_STEP = 2'd3;

  localparam logic [GRID_W-1:0] GRID_SIZE_RST  = 11'd1024;
  localparam logic [COEF_W-1:0] COEF_RST       = 16'd16384;
  localparam logic [COEF_W-1:0] COEF_FIRST_RST = 16'd8192;

  // contribution of one window tap to the laplacian
  typedef logic [1:0] gain_t;
  localparam gain_t GAIN_ADD  = 2'd0;
  localparam gain_t GAIN_SUB4 = 2'd1;

  typedef struct packed {
    logic               last;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } coord_t;

endpackage

FILE: hdl/wes_line_ram.sv
// wes_line_ram: one line of samples, one write and one registered read port
// read returns the old word on a same-address write; no dependencies
module wes_line_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/wes_win_cell.sv
// wes_win_cell: one tap of the stencil window; shifts in from its neighbor
// and adds its weighted value to the running laplacian; uses wes_pkg
module wes_win_cell (
  input  logic                              clk,
  input  logic                              shift,
  input  wes_pkg::gain_t                    gain,
  input  logic signed [wes_pkg::VAL_W-1:0]  d,
  input  logic signed [wes_pkg::LAP_W-1:0]  psum_in,
  output logic signed [wes_pkg::VAL_W-1:0]  q,
  output logic signed [wes_pkg::LAP_W-1:0]  psum_out
);

  localparam int LAP_W = wes_pkg::LAP_W;

  logic signed [LAP_W-1:0] q_ext;

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

  assign q_ext = LAP_W'(q);

  always_comb begin
    case (gain)
      wes_pkg::GAIN_ADD:  psum_out = psum_in + q_ext;
      wes_pkg::GAIN_SUB4: psum_out = psum_in - (q_ext <<< 2);
      default:            psum_out = psum_in;
    endcase
  end

endmodule

FILE: hdl/wave_equation_stencil_step.sv
// wave_equation_stencil_step: one fdtd step of the 2-d wave equation, raster in
// uses wes_pkg, wes_line_ram, wes_win_cell
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: cur_value[31:0] prev_value[63:32]
//  m_      | out | m_tvalid/m_tready  | m_tdata: new_value[31:0] row[41:32]
//          |     |                    |   col[51:42] zero[55:52]; m_tlast: last
//  cfg_    | in  | cfg_we             | cfg_index, cfg_data
//
// one grid point per clock sustained while m_tready stays high; a result reaches
// m_tvalid from the beat below its right neighbor through the registered line ram
// read, the laplacian register, the multiply register and the output register
// rst (synchronous) clears counters, valids and configuration registers; no clearing pass
// an output stall fills the three stages behind the output register before
// s_tready drops
module wave_equation_stencil_step #(
  parameter int MAX_GRID  = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [wes_pkg::IN_W-1:0]      s_tdata,   // cur_value, prev_value
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [wes_pkg::OUT_W-1:0]     m_tdata,   // new_value, row, col, zero pad
  output logic                          m_tlast,
  input  logic                          cfg_we,
  input  logic [wes_pkg::IDX_W-1:0]     cfg_index,
  input  logic [wes_pkg::CFG_W-1:0]     cfg_data
);

  localparam int VAL_W   = wes_pkg::VAL_W;
  localparam int LAP_W   = wes_pkg::LAP_W;
  localparam int COEF_W  = wes_pkg::COEF_W;
  localparam int COORD_W = wes_pkg::COORD_W;
  localparam int GRID_W  = wes_pkg::GRID_W;
  localparam int CNT_W   = $clog2(MAX_GRID);
  localparam int N_W     = $clog2(MAX_GRID + 1);
  localparam int G_W     = (N_W > GRID_W) ? N_W : GRID_W;
  localparam int PROD_W  = LAP_W + COEF_W + 1;
  localparam int SUM_W   = PROD_W + 1;
  localparam int PAD_W   = wes_pkg::OUT_W - VAL_W - 2 * COORD_W;

  // configuration
  logic [GRID_W-1:0] grid_size;
  logic [COEF_W-1:0] coef;
  logic [COEF_W-1:0] coef_first;
  logic              first_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size  <= wes_pkg::GRID_SIZE_RST;
      coef       <= wes_pkg::COEF_RST;
      coef_first <= wes_pkg::COEF_FIRST_RST;
      first_step <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        wes_pkg::REG_GRID_SIZE:  grid_size  <= cfg_data[GRID_W-1:0];
        wes_pkg::REG_COEF:       coef       <= cfg_data[COEF_W-1:0];
        wes_pkg::REG_COEF_FIRST: coef_first <= cfg_data[COEF_W-1:0];
        wes_pkg::REG_FIRST_STEP: first_step <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective grid side, clamped to 3..MAX_GRID
  logic [G_W-1:0] n_lim;
  logic [G_W-1:0] nm1;

  always_comb begin
    if (G_W'(grid_size) < G_W'(3)) begin
      n_lim = G_W'(3);
    end else if (G_W'(grid_size) > G_W'(MAX_GRID)) begin
      n_lim = G_W'(MAX_GRID);
    end else begin
      n_lim = G_W'(grid_size);
    end
  end

  assign nm1 = n_lim - G_W'(1);

  // pipeline control
  logic s1_v, s2_v, s3_v, o_v;
  logic s1_res;
  logic en_o, en3, en2, en1, s1_go, accept;

  assign en_o   = !o_v || m_tready;
  assign en3    = !s3_v || en_o;
  assign en2    = !s2_v || en3;
  assign s1_go  = s1_v && (en2 || !s1_res);
  assign en1    = !s1_v || s1_go;
  assign s_tready = en1;
  assign accept = s_tvalid && en1;

  // stage 0: raster counters
  logic [CNT_W-1:0] row_cnt, col_cnt;
  logic             row_end, row_wrap, res0;
  wes_pkg::coord_t  coord0;

  assign row_end  = G_W'(col_cnt) >= nm1;
  assign row_wrap = G_W'(row_cnt) >= nm1;
  assign res0     = (row_cnt >= CNT_W'(2)) && (col_cnt >= CNT_W'(2));

  always_comb begin
    coord0.row  = COORD_W'(row_cnt - CNT_W'(1));
    coord0.col  = COORD_W'(col_cnt - CNT_W'(1));
    coord0.last = (G_W'(row_cnt) == nm1) && (G_W'(col_cnt) == nm1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (accept) begin
      if (row_end) begin
        col_cnt <= '0;
        row_cnt <= row_wrap ? '0 : row_cnt + CNT_W'(1);
      end else begin
        col_cnt <= col_cnt + CNT_W'(1);
      end
    end
  end

  // line stores: two banks of current values by row parity, one of previous
  logic [VAL_W-1:0] bank0_q, bank1_q, prev_q;

  wes_line_ram #(.DEPTH(MAX_GRID), .WIDTH(VAL_W)) u_bank0 (
    .clk   (clk),
    .we    (accept && !row_cnt[0]),
    .waddr (col_cnt),
    .wdata (s_tdata[VAL_W-1:0]),
    .re    (accept),
    .raddr (col_cnt),
    .rdata (bank0_q)
  );

  wes_line_ram #(.DEPTH(MAX_GRID), .WIDTH(VAL_W)) u_bank1 (
    .clk   (clk),
    .we    (accept && row_cnt[0]),
    .waddr (col_cnt),
    .wdata (s_tdata[VAL_W-1:0]),
    .re    (accept),
    .raddr (col_cnt),
    .rdata (bank1_q)
  );

  wes_line_ram #(.DEPTH(MAX_GRID), .WIDTH(VAL_W)) u_prev (
    .clk   (clk),
    .we    (accept),
    .waddr (col_cnt),
    .wdata (s_tdata[2*VAL_W-1:VAL_W]),
    .re    (accept),
    .raddr (col_cnt),
    .rdata (prev_q)
  );

  // stage 1: window and laplacian
  logic                    s1_bank;
  logic signed [VAL_W-1:0] s1_u;
  wes_pkg::coord_t         s1_coord;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en1) begin
      s1_v <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_bank  <= row_cnt[0];
      s1_u     <= s_tdata[VAL_W-1:0];
      s1_coord <= coord0;
      s1_res   <= res0;
    end
  end

  logic signed [VAL_W-1:0] top_s, mid_s;
  logic signed [VAL_W-1:0] prev_dly;

  assign top_s = s1_bank ? bank1_q : bank0_q;
  assign mid_s = s1_bank ? bank0_q : bank1_q;

  // previous value at the centre point comes one beat behind its read
  always_ff @(posedge clk) begin
    if (s1_go) begin
      prev_dly <= prev_q;
    end
  end

  logic signed [VAL_W-1:0] bot_q, top_q, ctr_q, left_q;
  logic signed [LAP_W-1:0] ps_bot, ps_top, ps_left, lap1;

  // running sum starts with the right neighbor straight from the ram
  wes_win_cell u_cell_bot (
    .clk (clk), .shift (s1_go), .gain (wes_pkg::GAIN_ADD),
    .d (s1_u), .psum_in (LAP_W'(mid_s)), .q (bot_q), .psum_out (ps_bot)
  );

  wes_win_cell u_cell_top (
    .clk (clk), .shift (s1_go), .gain (wes_pkg::GAIN_ADD),
    .d (top_s), .psum_in (ps_bot), .q (top_q), .psum_out (ps_top)
  );

  wes_win_cell u_cell_left (
    .clk (clk), .shift (s1_go), .gain (wes_pkg::GAIN_ADD),
    .d (ctr_q), .psum_in (ps_top), .q (left_q), .psum_out (ps_left)
  );

  wes_win_cell u_cell_ctr (
    .clk (clk), .shift (s1_go), .gain (wes_pkg::GAIN_SUB4),
    .d (mid_s), .psum_in (ps_left), .q (ctr_q), .psum_out (lap1)
  );

  // stage 2: multiply
  logic signed [LAP_W-1:0] s2_lap;
  logic signed [VAL_W-1:0] s2_ctr, s2_pd;
  wes_pkg::coord_t         s2_coord;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en2) begin
      s2_v <= s1_v && s1_res;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_lap   <= lap1;
      s2_ctr   <= ctr_q;
      s2_pd    <= prev_dly;
      s2_coord <= s1_coord;
    end
  end

  logic [COEF_W-1:0]        gain_sel;
  logic signed [COEF_W:0]   gain_s;
  logic signed [PROD_W-1:0] prod2;
  logic signed [SUM_W-1:0]  base2;

  assign gain_sel = first_step ? coef_first : coef;
  assign gain_s   = $signed({1'b0, gain_sel});
  assign prod2    = PROD_W'(s2_lap) * PROD_W'(gain_s);
  assign base2    = first_step ? SUM_W'(s2_ctr)
                               : (SUM_W'(s2_ctr) <<< 1) - SUM_W'(s2_pd);

  // stage 3: shift, add, saturate
  logic signed [PROD_W-1:0] s3_prod;
  logic signed [SUM_W-1:0]  s3_base;
  wes_pkg::coord_t          s3_coord;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en3) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_prod  <= prod2;
      s3_base  <= base2;
      s3_coord <= s2_coord;
    end
  end

  logic signed [SUM_W-1:0] sum3;
  logic [VAL_W-1:0]        sat3;
  logic [SUM_W-VAL_W:0]    hi3;

  // arithmetic shift floors toward minus infinity
  assign sum3 = s3_base + SUM_W'(s3_prod >>> FRAC_BITS);
  assign hi3  = sum3[SUM_W-1:VAL_W-1];

  always_comb begin
    if ((hi3 == '0) || (hi3 == '1)) begin
      sat3 = sum3[VAL_W-1:0];
    end else if (sum3[SUM_W-1]) begin
      sat3 = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat3 = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  // output register
  logic [VAL_W-1:0] o_value;
  wes_pkg::coord_t  o_coord;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (en_o) begin
      o_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      o_value <= sat3;
      o_coord <= s3_coord;
    end
  end

  assign m_tvalid = o_v;
  assign m_tdata  = {{PAD_W{1'b0}}, o_coord.col, o_coord.row, o_value};
  assign m_tlast  = o_coord.last;

endmodule

FILE: hdl/wes_checker.sv
// wes_checker: port-level checks on the stencil step output stream
// bound to wave_equation_stencil_step; uses wes_pkg
module wes_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [wes_pkg::OUT_W-1:0] m_tdata,
  input logic                      m_tlast
);

  // no result can be pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result beat changed");

  // the final interior point sits on the diagonal
  a_last_diag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[41:32] == m_tdata[51:42])
    else $error("last beat is not on the diagonal");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[55:52] == 4'd0)
    else $error("pad bits of result beat not zero");

endmodule

bind wave_equation_stencil_step wes_checker u_wes_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
